@@ src/nfa_pkg.sv @@
// Package with the shared types and constants of the NFA line matcher.
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

   localparam logic [1:0] MODE_ENTRY = 2'd0;
   localparam logic [1:0] MODE_CLASS = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_EMPTY = 2'd3;

   localparam logic [2:0] KIND_CONSUME = 3'd0;
   localparam logic [2:0] KIND_SPLIT   = 3'd1;
   localparam logic [2:0] KIND_MATCH   = 3'd2;
   localparam logic [2:0] KIND_BOL     = 3'd3;
   localparam logic [2:0] KIND_EOL     = 3'd4;

   localparam logic [1:0] TEST_LITERAL = 2'd0;
   localparam logic [1:0] TEST_ANY     = 2'd1;
   localparam logic [1:0] TEST_CLASS   = 2'd2;

   localparam logic CSR_START_STATE = 1'b0;
   localparam logic CSR_CASE_FOLD   = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] test;
      logic [7:0] lit;
      logic       neg;
      logic [3:0] cls;
      logic [8:0] succ1;
      logic [8:0] succ2;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic line_init;
      logic line_clear;
      logic setup_held;
      logic setup_cur;
      logic hold_cur;
      logic idx_inc;
      logic state_rd;
      logic class_rd;
      logic step_apply;
      logic close_apply;
      logic copy_next;
      logic close_restart;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic active_bit;
      logic idx_last;
      logic changed;
      logic line_started;
      logic held_valid;
      logic cur_empty;
      logic cur_last;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

@@ src/nfa_ifs.sv @@
// Request and response channel interfaces of the NFA line matcher.
`timescale 1ns / 1ps
`default_nettype none
interface nfa_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [7:0]        entry_index;
   logic [2:0]        entry_kind;
   logic [1:0]        byte_test;
   logic [7:0]        byte_value;
   logic              negate;
   logic signed [8:0] next_primary;
   logic signed [8:0] next_secondary;
   logic [3:0]        class_index;
   logic [1:0]        word_select;
   logic [63:0]       class_bits;
   logic              last_of_line;
   modport source (output valid, mode, entry_index, entry_kind, byte_test, byte_value,
                   negate, next_primary, next_secondary, class_index, word_select,
                   class_bits, last_of_line, input ready);
   modport sink (input valid, mode, entry_index, entry_kind, byte_test, byte_value,
                 negate, next_primary, next_secondary, class_index, word_select,
                 class_bits, last_of_line, output ready);
endinterface

interface nfa_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   modport source (output valid, matched, input ready);
   modport sink (input valid, matched, output ready);
endinterface
`default_nettype wire

@@ src/nfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ src/nfa_ctrl.sv @@
// Controller state machine that sequences line start, byte steps and closure sweeps.
`timescale 1ns / 1ps
`default_nettype none
module nfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_mode,
   input  wire nfa_pkg::status_type sts,
   output nfa_pkg::cmd_type        cmd,
   output logic                    req_ready
);
   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_NEXT       = 10'b0000000010,
      S_STEP_SCAN  = 10'b0000000100,
      S_STEP_ENT   = 10'b0000001000,
      S_STEP_EVAL  = 10'b0000010000,
      S_STEP_COPY  = 10'b0000100000,
      S_CLOSE_SCAN = 10'b0001000000,
      S_CLOSE_ENT  = 10'b0010000000,
      S_CLOSE_END  = 10'b0100000000,
      S_EMIT       = 10'b1000000000
   } state_type;

   typedef enum logic [3:0] {
      STG_ENTRY = 4'b0001,
      STG_BEGIN = 4'b0010,
      STG_HELD  = 4'b0100,
      STG_LAST  = 4'b1000
   } stage_type;

   state_type state_ff, state_in;
   stage_type stage_ff, stage_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = 1'b1;
            if (req_valid && (req_mode == nfa_pkg::MODE_DATA ||
                              req_mode == nfa_pkg::MODE_EMPTY)) begin
               state_in = S_NEXT;
               stage_in = STG_ENTRY;
            end
         end
         S_NEXT: begin
            if ((stage_ff == STG_ENTRY) && (sts.cur_empty || !sts.line_started)) begin
               cmd.line_init = 1'b1;
               stage_in      = STG_BEGIN;
               state_in      = S_CLOSE_SCAN;
            end else if (stage_ff == STG_LAST ||
                         (stage_ff == STG_BEGIN && sts.cur_empty)) begin
               state_in = S_EMIT;
            end else if (stage_ff != STG_HELD && sts.held_valid) begin
               cmd.setup_held = 1'b1;
               stage_in       = STG_HELD;
               state_in       = S_STEP_SCAN;
            end else begin
               cmd.hold_cur = 1'b1;
               if (sts.cur_last) begin
                  cmd.setup_cur = 1'b1;
                  stage_in      = STG_LAST;
                  state_in      = S_STEP_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_STEP_SCAN: begin
            if (sts.active_bit) begin
               cmd.state_rd = 1'b1;
               state_in     = S_STEP_ENT;
            end else if (sts.idx_last) begin
               state_in = S_STEP_COPY;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_STEP_ENT: begin
            cmd.class_rd = 1'b1;
            state_in     = S_STEP_EVAL;
         end
         S_STEP_EVAL: begin
            cmd.step_apply = 1'b1;
            if (sts.idx_last) begin
               state_in = S_STEP_COPY;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_STEP_SCAN;
            end
         end
         S_STEP_COPY: begin
            cmd.copy_next = 1'b1;
            state_in      = S_CLOSE_SCAN;
         end
         S_CLOSE_SCAN: begin
            if (sts.active_bit) begin
               cmd.state_rd = 1'b1;
               state_in     = S_CLOSE_ENT;
            end else if (sts.idx_last) begin
               state_in = S_CLOSE_END;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_CLOSE_ENT: begin
            cmd.close_apply = 1'b1;
            if (sts.idx_last) begin
               state_in = S_CLOSE_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CLOSE_SCAN;
            end
         end
         S_CLOSE_END: begin
            if (sts.changed) begin
               cmd.close_restart = 1'b1;
               state_in          = S_CLOSE_SCAN;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit       = 1'b1;
               cmd.line_clear = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stage_ff <= STG_ENTRY;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
      end
   end
endmodule
`default_nettype wire

@@ src/nfa_datapath.sv @@
// Datapath with the state and class tables, the active sets and the line registers.
`timescale 1ns / 1ps
`default_nettype none
module nfa_datapath #(
   parameter int NUM_STATES  = 256,
   parameter int NUM_CLASSES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   nfa_req_if.sink                  req,
   nfa_rsp_if.source                rsp,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [7:0]          csr_wr_data,
   input  wire nfa_pkg::cmd_type    cmd,
   output nfa_pkg::status_type      sts
);
   localparam int SW  = $clog2(NUM_STATES);
   localparam int CD  = NUM_CLASSES * 4;
   localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
   localparam int EW  = $bits(nfa_pkg::entry_type);

   logic [NUM_STATES-1:0] active_ff, active_in, next_ff, next_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [7:0]            held_byte_ff, held_byte_in, cur_byte_ff, step_byte_ff, step_byte_in;
   logic                  held_valid_ff, held_valid_in, line_started_ff, line_started_in;
   logic                  match_ff, match_in, changed_ff, changed_in;
   logic                  cur_last_ff, cur_empty_ff, bol_fire_ff, bol_fire_in;
   logic                  at_end_ff, at_end_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_matched_ff;
   logic [7:0]            start_state_ff;
   logic                  case_fold_ff;

   logic                  fire, st_wr, cl_wr, cur_nl;
   nfa_pkg::entry_type    wr_entry, ent;
   logic [EW-1:0]         st_rdata;
   logic [63:0]           cl_rdata;
   logic [CAW-1:0]        cl_wr_addr, cl_rd_addr;
   logic [7:0]            folded;
   logic                  cls_in, byte_ok, t1_en, t2_en;
   logic [NUM_STATES-1:0] one_hot1, one_hot2, add_set, start_set;

   function automatic logic succ_ok(input logic [8:0] raw);
      succ_ok = !raw[8] && (32'(raw[7:0]) < NUM_STATES);
   endfunction

   function automatic logic [NUM_STATES-1:0] bit_of(input logic [7:0] s);
      bit_of = {{(NUM_STATES-1){1'b0}}, 1'b1} << SW'(s);
   endfunction

   assign fire   = cmd.accept && req.valid;
   assign st_wr  = fire && (req.mode == nfa_pkg::MODE_ENTRY) &&
                   (32'(req.entry_index) < NUM_STATES);
   assign cl_wr  = fire && (req.mode == nfa_pkg::MODE_CLASS) &&
                   (32'(req.class_index) < NUM_CLASSES);
   assign cl_wr_addr = CAW'({req.class_index, req.word_select});

   always_comb begin
      wr_entry.kind  = req.entry_kind;
      wr_entry.test  = req.byte_test;
      wr_entry.lit   = req.byte_value;
      wr_entry.neg   = req.negate;
      wr_entry.cls   = req.class_index;
      wr_entry.succ1 = req.next_primary;
      wr_entry.succ2 = req.next_secondary;
   end

   nfa_ram #(.WIDTH(EW), .DEPTH(NUM_STATES)) u_state_ram (
      .clock  (clock),
      .wr_en  (st_wr),
      .wr_addr(SW'(req.entry_index)),
      .wr_data(wr_entry),
      .rd_en  (cmd.state_rd),
      .rd_addr(idx_ff),
      .rd_data(st_rdata)
   );

   assign ent        = nfa_pkg::entry_type'(st_rdata);
   assign cl_rd_addr = CAW'({ent.cls, step_byte_ff[7:6]});

   nfa_ram #(.WIDTH(64), .DEPTH(CD)) u_class_ram (
      .clock  (clock),
      .wr_en  (cl_wr),
      .wr_addr(cl_wr_addr),
      .wr_data(req.class_bits),
      .rd_en  (cmd.class_rd),
      .rd_addr(cl_rd_addr),
      .rd_data(cl_rdata)
   );

   assign cur_nl = (cur_byte_ff == nfa_pkg::CHAR_NEWLINE);

   always_comb begin
      folded = step_byte_ff;
      if (case_fold_ff && step_byte_ff >= nfa_pkg::CHAR_UPPER_A &&
          step_byte_ff <= nfa_pkg::CHAR_UPPER_Z) begin
         folded = step_byte_ff + (nfa_pkg::CHAR_LOWER_A - nfa_pkg::CHAR_UPPER_A);
      end
      cls_in = (32'(ent.cls) < NUM_CLASSES) && cl_rdata[step_byte_ff[5:0]];
      unique case (ent.test)
         nfa_pkg::TEST_LITERAL: byte_ok = (folded == ent.lit);
         nfa_pkg::TEST_ANY:     byte_ok = (step_byte_ff != nfa_pkg::CHAR_NEWLINE);
         nfa_pkg::TEST_CLASS:   byte_ok = cls_in ^ ent.neg;
         default:               byte_ok = 1'b0;
      endcase
   end

   always_comb begin
      t1_en = succ_ok(ent.succ1) &&
              ((ent.kind == nfa_pkg::KIND_SPLIT) ||
               (ent.kind == nfa_pkg::KIND_BOL && bol_fire_ff) ||
               (ent.kind == nfa_pkg::KIND_EOL && at_end_ff));
      t2_en = succ_ok(ent.succ2) && (ent.kind == nfa_pkg::KIND_SPLIT);
      one_hot1 = bit_of(ent.succ1[7:0]);
      one_hot2 = bit_of(ent.succ2[7:0]);
      add_set  = (t1_en ? one_hot1 : '0) | (t2_en ? one_hot2 : '0);
      start_set = (32'(start_state_ff) < NUM_STATES) ? bit_of(start_state_ff) : '0;
   end

   always_comb begin
      active_in       = active_ff;
      next_in         = next_ff;
      idx_in          = idx_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      line_started_in = line_started_ff;
      match_in        = match_ff;
      changed_in      = changed_ff;
      step_byte_in    = step_byte_ff;
      bol_fire_in     = bol_fire_ff;
      at_end_in       = at_end_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;

      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.step_apply && ent.kind == nfa_pkg::KIND_CONSUME &&
          succ_ok(ent.succ1) && byte_ok) begin
         next_in = next_ff | one_hot1;
      end
      if (cmd.close_apply) begin
         active_in = active_ff | add_set;
         if ((add_set & ~active_ff) != '0) begin
            changed_in = 1'b1;
         end
         if (ent.kind == nfa_pkg::KIND_MATCH) begin
            match_in = 1'b1;
         end
      end
      if (cmd.copy_next) begin
         active_in  = next_ff;
         next_in    = '0;
         idx_in     = '0;
         changed_in = 1'b0;
      end
      if (cmd.close_restart) begin
         idx_in     = '0;
         changed_in = 1'b0;
      end
      if (cmd.setup_held) begin
         step_byte_in = held_byte_ff;
         bol_fire_in  = (held_byte_ff == nfa_pkg::CHAR_NEWLINE);
         at_end_in    = cur_nl;
         idx_in       = '0;
      end
      if (cmd.hold_cur) begin
         held_byte_in  = cur_byte_ff;
         held_valid_in = 1'b1;
      end
      if (cmd.setup_cur) begin
         step_byte_in = cur_byte_ff;
         bol_fire_in  = cur_nl;
         at_end_in    = 1'b1;
         idx_in       = '0;
      end
      if (cmd.line_init) begin
         active_in       = start_set;
         next_in         = '0;
         held_byte_in    = '0;
         held_valid_in   = 1'b0;
         match_in        = 1'b0;
         line_started_in = 1'b1;
         bol_fire_in     = 1'b1;
         at_end_in       = cur_empty_ff || cur_nl;
         idx_in          = '0;
         changed_in      = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.line_clear) begin
         active_in       = '0;
         next_in         = '0;
         held_byte_in    = '0;
         held_valid_in   = 1'b0;
         line_started_in = 1'b0;
         match_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= '0;
         next_ff         <= '0;
         idx_ff          <= '0;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         line_started_ff <= 1'b0;
         match_ff        <= 1'b0;
         changed_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         start_state_ff  <= '0;
         case_fold_ff    <= 1'b0;
      end else begin
         active_ff       <= active_in;
         next_ff         <= next_in;
         idx_ff          <= idx_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         line_started_ff <= line_started_in;
         match_ff        <= match_in;
         changed_ff      <= changed_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               nfa_pkg::CSR_START_STATE: start_state_ff <= csr_wr_data;
               nfa_pkg::CSR_CASE_FOLD:   case_fold_ff   <= csr_wr_data[0];
               default:                  start_state_ff <= start_state_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      step_byte_ff <= step_byte_in;
      bol_fire_ff  <= bol_fire_in;
      at_end_ff    <= at_end_in;
      if (fire) begin
         cur_byte_ff  <= req.byte_value;
         cur_last_ff  <= req.last_of_line;
         cur_empty_ff <= (req.mode == nfa_pkg::MODE_EMPTY);
      end
      if (cmd.emit) begin
         rsp_matched_ff <= match_ff;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.matched = rsp_matched_ff;

   always_comb begin
      sts.active_bit   = active_ff[idx_ff];
      sts.idx_last     = (idx_ff == SW'(NUM_STATES - 1));
      sts.changed      = changed_ff;
      sts.line_started = line_started_ff;
      sts.held_valid   = held_valid_ff;
      sts.cur_empty    = cur_empty_ff;
      sts.cur_last     = cur_last_ff;
      sts.out_busy     = rsp_valid_ff && !rsp.ready;
   end
endmodule
`default_nettype wire

@@ src/nfa_regex_line_matcher.sv @@
// Top level of the NFA line matcher: controller, datapath and request handshake.
//
// Requests arrive on req (valid/ready). Modes 0 and 1 write a state entry or a
// 64-bit class word. Mode 2 feeds one byte of a line, mode 3 evaluates an
// empty line. One byte is held back to settle line-end anchors, so each byte
// runs the step for the byte before it.
// A step sweeps all NUM_STATES entries of the active set; an active entry takes
// a state RAM read, a class RAM read and an update. The closure then sweeps
// the set again, an active entry taking a state RAM read and an update, and
// repeats while a sweep adds states. The final byte of a line pays for two steps.
// A request is accepted only while the controller is idle.
// At the end of a line one response on rsp carries matched. It sits in an
// output register; a stalled receiver holds the block only when the next
// response is ready to be written. Reset clears the line state and the
// configuration; the tables are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module nfa_regex_line_matcher #(
   parameter int NUM_STATES  = 256,
   parameter int NUM_CLASSES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   nfa_req_if.sink         req,
   nfa_rsp_if.source       rsp,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wr_data
);
   nfa_pkg::cmd_type    cmd;
   nfa_pkg::status_type sts;
   logic                ready;

   assign req.ready = ready;

   nfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_mode (req.mode),
      .sts      (sts),
      .cmd      (cmd),
      .req_ready(ready)
   );

   nfa_datapath #(.NUM_STATES(NUM_STATES), .NUM_CLASSES(NUM_CLASSES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .sts        (sts)
   );
endmodule
`default_nettype wire

@@ src/nfa_checker.sv @@
// Port-level checker of the NFA line matcher and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nfa_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_mode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_matched
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_matched))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == nfa_pkg::MODE_ENTRY ||
                                 req_mode == nfa_pkg::MODE_CLASS) |=> !$rose(rsp_valid))
      else $error("table load produced a response");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == nfa_pkg::MODE_DATA ||
                                 req_mode == nfa_pkg::MODE_EMPTY) |=> !req_ready)
      else $error("line request did not occupy the block");
endmodule

bind nfa_regex_line_matcher nfa_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_mode   (req.mode),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_matched(rsp.matched)
);
`default_nettype wire
